// ===== design/ugnb_pkg.sv =====
// ----------------------------------------------------------------------------
// Uniform grid binning package
// Item kinds, result status codes, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ugnb_pkg;

  localparam int KIND_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int RADIUS_BITS   = 23;
  localparam int SHIFT_BITS    = 5;
  localparam int DIM_CFG_BITS  = 5;
  localparam int CFG_ADDR_BITS = 3;
  localparam int MAX_OUT       = 64;

  localparam logic [KIND_BITS-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_ADD   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_OUTSIDE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_TRUNC   = 2'd3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_Z   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELL_SHIFT = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELLS_X    = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELLS_Y    = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELLS_Z    = 3'd6;

endpackage

`default_nettype wire

// ===== design/uniform_grid_neighbor_binning.sv =====
// ----------------------------------------------------------------------------
// Uniform grid neighbour binning
// Bins agent ids into a 3-D grid of cells and answers neighbourhood queries.
// ----------------------------------------------------------------------------
// Usage: items arrive on the in channel (valid/ready) and results leave on the
// out channel (valid/ready) through a single output register. Registers are
// to be written on the cfg channel, which is always ready, only while the
// block is idle; the block leaves this to the user. An item is taken only
// when the sequencer is idle; one item at a time. An add steps through cell
// address, fill read, slot write and result. A query checks each cell and
// reads its fill, then reads each id found, over up to 27 cells and 64 ids,
// its pace set by the single fill and slot memory read ports driven by the
// shared cell address unit. A clear sweeps the fill memory, then gives its
// result. After reset the same sweep runs before the first item is taken;
// configuration transfers are taken during it.
// When the receiver stalls, the sequencer holds at its next result and
// resumes as soon as the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module uniform_grid_neighbor_binning #(
  parameter int GRID_MAX_DIM    = 16,
  parameter int SLOTS_PER_CELL  = 8,
  parameter int MAX_CELL_RADIUS = 1,
  parameter int ID_BITS         = 10,
  parameter int POS_BITS        = 24
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [ugnb_pkg::KIND_BITS-1:0]       kind_i,
  input  wire logic [ID_BITS-1:0]                   agent_id_i,
  input  wire logic signed [POS_BITS-1:0]           pos_x_i,
  input  wire logic signed [POS_BITS-1:0]           pos_y_i,
  input  wire logic signed [POS_BITS-1:0]           pos_z_i,
  input  wire logic [ugnb_pkg::RADIUS_BITS-1:0]     search_radius_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [ID_BITS-1:0]                        found_id_o,
  output logic                                      found_valid_o,
  output logic [ugnb_pkg::STATUS_BITS-1:0]          status_o,
  output logic                                      last_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [ugnb_pkg::CFG_ADDR_BITS-1:0]   cfg_addr_i,
  input  wire logic [POS_BITS-1:0]                  cfg_data_i
);

  localparam int NUM_CELLS = GRID_MAX_DIM * GRID_MAX_DIM * GRID_MAX_DIM;
  localparam int NUM_SLOTS = NUM_CELLS * SLOTS_PER_CELL;
  localparam int CW  = $clog2(NUM_CELLS);
  localparam int SW  = $clog2(NUM_SLOTS);
  localparam int FW  = $clog2(SLOTS_PER_CELL + 1);
  localparam int DW  = $clog2(GRID_MAX_DIM + 1);
  localparam int CRW = POS_BITS + 2;
  localparam int OW  = $clog2(MAX_CELL_RADIUS + 1) + 1;
  localparam int NW  = $clog2(ugnb_pkg::MAX_OUT + 1);
  localparam int RB  = ugnb_pkg::RADIUS_BITS;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_ADD_CK = 4'd3;
  localparam logic [3:0] S_ADD_WR = 4'd4;
  localparam logic [3:0] S_RESP   = 4'd5;
  localparam logic [3:0] S_Q_CELL = 4'd6;
  localparam logic [3:0] S_Q_FILL = 4'd7;
  localparam logic [3:0] S_Q_RD   = 4'd8;
  localparam logic [3:0] S_Q_DATA = 4'd9;
  localparam logic [3:0] S_Q_END  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;

  logic signed [POS_BITS-1:0] org_x_q, org_y_q, org_z_q;
  logic [ugnb_pkg::SHIFT_BITS-1:0] shift_q;
  logic [ugnb_pkg::DIM_CFG_BITS-1:0] cfg_cx_q, cfg_cy_q, cfg_cz_q;

  logic signed [CRW-1:0] cell_x_q, cell_x_d, cell_y_q, cell_y_d, cell_z_q, cell_z_d;
  logic [DW-1:0] dim_x_q, dim_x_d, dim_y_q, dim_y_d, dim_z_q, dim_z_d;
  logic [CW-1:0] cxy_q, cxy_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic signed [OW-1:0] rad_q, rad_d, dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic [CW-1:0] n_q, n_d;
  logic [FW-1:0] fcnt_q, fcnt_d, slot_i_q, slot_i_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic pend_vld_q, pend_vld_d;
  logic [ID_BITS-1:0] pend_id_q, pend_id_d;
  logic [ugnb_pkg::STATUS_BITS-1:0] resp_st_q, resp_st_d;

  logic out_vld_q, out_fv_q, out_last_q;
  logic [ID_BITS-1:0] out_id_q;
  logic [ugnb_pkg::STATUS_BITS-1:0] out_st_q;

  logic push, push_fv, push_last, can_push;
  logic [ID_BITS-1:0] push_id;
  logic [ugnb_pkg::STATUS_BITS-1:0] push_st;

  logic [FW-1:0] fill_store [NUM_CELLS];
  logic [ID_BITS-1:0] slot_store [NUM_SLOTS];
  logic fill_we, fill_re, slot_we, slot_re;
  logic [CW-1:0] fill_wa, fill_ra;
  logic [FW-1:0] fill_wd, fill_rd_q;
  logic [SW-1:0] slot_addr;
  logic [ID_BITS-1:0] slot_rd_q;
  logic [FW-1:0] slot_sel;

  // Shared cell address unit.
  logic signed [CRW-1:0] nx, ny, nz;
  logic cell_ok;
  logic [CW-1:0] n_calc;

  logic signed [POS_BITS:0] dpx, dpy, dpz;
  logic [RB:0] crad;
  logic [RB-1:0] rmask;

  logic adv_done;
  logic signed [OW-1:0] adv_dx, adv_dy, adv_dz;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign can_push    = !out_vld_q || out_ready_i;

  assign out_valid_o   = out_vld_q;
  assign found_id_o    = out_id_q;
  assign found_valid_o = out_fv_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;

  assign nx = cell_x_q + CRW'(dx_q);
  assign ny = cell_y_q + CRW'(dy_q);
  assign nz = cell_z_q + CRW'(dz_q);
  assign cell_ok = (nx >= 0) && (nx < $signed({{(CRW-DW){1'b0}}, dim_x_q})) &&
                   (ny >= 0) && (ny < $signed({{(CRW-DW){1'b0}}, dim_y_q})) &&
                   (nz >= 0) && (nz < $signed({{(CRW-DW){1'b0}}, dim_z_q}));
  assign n_calc = CW'(nx) + CW'(CW'(ny) * CW'(dim_x_q)) + CW'(CW'(nz) * cxy_q);

  assign dpx = $signed({pos_x_i[POS_BITS-1], pos_x_i}) -
               $signed({org_x_q[POS_BITS-1], org_x_q});
  assign dpy = $signed({pos_y_i[POS_BITS-1], pos_y_i}) -
               $signed({org_y_q[POS_BITS-1], org_y_q});
  assign dpz = $signed({pos_z_i[POS_BITS-1], pos_z_i}) -
               $signed({org_z_q[POS_BITS-1], org_z_q});

  assign rmask = ~({RB{1'b1}} << shift_q);
  assign crad  = {1'b0, search_radius_i >> shift_q} +
                 (RB+1)'(|(search_radius_i & rmask));

  assign slot_sel  = (state_q == S_ADD_WR) ? fill_rd_q : slot_i_q;
  assign slot_addr = SW'(n_q) * SW'(SLOTS_PER_CELL) + SW'(slot_sel);

  always_comb begin
    adv_done = 1'b0;
    adv_dx = dx_q;
    adv_dy = dy_q;
    adv_dz = dz_q;
    if (dz_q != rad_q) begin
      adv_dz = dz_q + OW'(1);
    end else if (dy_q != rad_q) begin
      adv_dz = -rad_q;
      adv_dy = dy_q + OW'(1);
    end else if (dx_q != rad_q) begin
      adv_dz = -rad_q;
      adv_dy = -rad_q;
      adv_dx = dx_q + OW'(1);
    end else begin
      adv_done = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cell_x_d   = cell_x_q;
    cell_y_d   = cell_y_q;
    cell_z_d   = cell_z_q;
    dim_x_d    = dim_x_q;
    dim_y_d    = dim_y_q;
    dim_z_d    = dim_z_q;
    cxy_d      = cxy_q;
    id_d       = id_q;
    rad_d      = rad_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    dz_d       = dz_q;
    n_d        = n_q;
    fcnt_d     = fcnt_q;
    slot_i_d   = slot_i_q;
    cnt_d      = cnt_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    resp_st_d  = resp_st_q;
    push       = 1'b0;
    push_id    = '0;
    push_fv    = 1'b0;
    push_st    = ugnb_pkg::ST_OK;
    push_last  = 1'b0;
    fill_we    = 1'b0;
    fill_wa    = clr_cnt_q;
    fill_wd    = '0;
    fill_re    = 1'b0;
    fill_ra    = n_calc;
    slot_we    = 1'b0;
    slot_re    = 1'b0;

    case (state_q)
      S_INIT, S_CLR: begin
        fill_we = 1'b1;
        if (clr_cnt_q == CW'(NUM_CELLS - 1)) begin
          clr_cnt_d = '0;
          resp_st_d = ugnb_pkg::ST_OK;
          state_d   = (state_q == S_INIT) ? S_IDLE : S_RESP;
        end else begin
          clr_cnt_d = clr_cnt_q + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cell_x_d = CRW'(dpx >>> shift_q);
          cell_y_d = CRW'(dpy >>> shift_q);
          cell_z_d = CRW'(dpz >>> shift_q);
          dim_x_d = (32'(cfg_cx_q) > GRID_MAX_DIM) ? DW'(GRID_MAX_DIM) : DW'(cfg_cx_q);
          dim_y_d = (32'(cfg_cy_q) > GRID_MAX_DIM) ? DW'(GRID_MAX_DIM) : DW'(cfg_cy_q);
          dim_z_d = (32'(cfg_cz_q) > GRID_MAX_DIM) ? DW'(GRID_MAX_DIM) : DW'(cfg_cz_q);
          cxy_d = CW'(CW'(dim_x_d) * CW'(dim_y_d));
          id_d  = agent_id_i;
          if (crad > (RB+1)'(MAX_CELL_RADIUS)) begin
            rad_d = OW'(MAX_CELL_RADIUS);
          end else begin
            rad_d = OW'(crad);
          end
          cnt_d      = '0;
          pend_vld_d = 1'b0;
          case (kind_i)
            ugnb_pkg::KIND_CLEAR: begin
              state_d = S_CLR;
            end
            ugnb_pkg::KIND_ADD: begin
              dx_d = '0;
              dy_d = '0;
              dz_d = '0;
              state_d = S_ADD_CK;
            end
            ugnb_pkg::KIND_QUERY: begin
              dx_d = -rad_d;
              dy_d = -rad_d;
              dz_d = -rad_d;
              state_d = S_Q_CELL;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_CK: begin
        if (cell_ok) begin
          fill_re = 1'b1;
          n_d     = n_calc;
          state_d = S_ADD_WR;
        end else begin
          resp_st_d = ugnb_pkg::ST_OUTSIDE;
          state_d   = S_RESP;
        end
      end
      S_ADD_WR: begin
        if (fill_rd_q >= FW'(SLOTS_PER_CELL)) begin
          resp_st_d = ugnb_pkg::ST_FULL;
        end else begin
          fill_we   = 1'b1;
          fill_wa   = n_q;
          fill_wd   = fill_rd_q + FW'(1);
          slot_we   = 1'b1;
          resp_st_d = ugnb_pkg::ST_OK;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (can_push) begin
          push      = 1'b1;
          push_st   = resp_st_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_Q_CELL: begin
        if (cell_ok) begin
          fill_re = 1'b1;
          n_d     = n_calc;
          state_d = S_Q_FILL;
        end else begin
          dx_d = adv_dx;
          dy_d = adv_dy;
          dz_d = adv_dz;
          state_d = adv_done ? S_Q_END : S_Q_CELL;
        end
      end
      S_Q_FILL: begin
        fcnt_d   = fill_rd_q;
        slot_i_d = '0;
        if (fill_rd_q == '0) begin
          dx_d = adv_dx;
          dy_d = adv_dy;
          dz_d = adv_dz;
          state_d = adv_done ? S_Q_END : S_Q_CELL;
        end else begin
          state_d = S_Q_RD;
        end
      end
      S_Q_RD: begin
        slot_re = 1'b1;
        state_d = S_Q_DATA;
      end
      S_Q_DATA: begin
        if (pend_vld_q && (cnt_q == NW'(ugnb_pkg::MAX_OUT))) begin
          if (can_push) begin
            push      = 1'b1;
            push_id   = pend_id_q;
            push_fv   = 1'b1;
            push_st   = ugnb_pkg::ST_TRUNC;
            push_last = 1'b1;
            state_d   = S_IDLE;
          end
        end else if (!pend_vld_q || can_push) begin
          if (pend_vld_q) begin
            push    = 1'b1;
            push_id = pend_id_q;
            push_fv = 1'b1;
          end
          pend_vld_d = 1'b1;
          pend_id_d  = slot_rd_q;
          cnt_d      = cnt_q + NW'(1);
          if (slot_i_q + FW'(1) == fcnt_q) begin
            dx_d = adv_dx;
            dy_d = adv_dy;
            dz_d = adv_dz;
            state_d = adv_done ? S_Q_END : S_Q_CELL;
          end else begin
            slot_i_d = slot_i_q + FW'(1);
            state_d  = S_Q_RD;
          end
        end
      end
      S_Q_END: begin
        if (can_push) begin
          push      = 1'b1;
          push_id   = pend_vld_q ? pend_id_q : '0;
          push_fv   = pend_vld_q;
          push_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_store[fill_wa] <= fill_wd;
    end
    if (fill_re) begin
      fill_rd_q <= fill_store[fill_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_store[slot_addr] <= id_q;
    end
    if (slot_re) begin
      slot_rd_q <= slot_store[slot_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      clr_cnt_q  <= '0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      org_z_q    <= '0;
      shift_q    <= ugnb_pkg::SHIFT_BITS'(8);
      cfg_cx_q   <= ugnb_pkg::DIM_CFG_BITS'(16);
      cfg_cy_q   <= ugnb_pkg::DIM_CFG_BITS'(16);
      cfg_cz_q   <= ugnb_pkg::DIM_CFG_BITS'(16);
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          ugnb_pkg::REG_ORIGIN_X:   org_x_q  <= cfg_data_i;
          ugnb_pkg::REG_ORIGIN_Y:   org_y_q  <= cfg_data_i;
          ugnb_pkg::REG_ORIGIN_Z:   org_z_q  <= cfg_data_i;
          ugnb_pkg::REG_CELL_SHIFT: shift_q  <= cfg_data_i[ugnb_pkg::SHIFT_BITS-1:0];
          ugnb_pkg::REG_CELLS_X:    cfg_cx_q <= cfg_data_i[ugnb_pkg::DIM_CFG_BITS-1:0];
          ugnb_pkg::REG_CELLS_Y:    cfg_cy_q <= cfg_data_i[ugnb_pkg::DIM_CFG_BITS-1:0];
          ugnb_pkg::REG_CELLS_Z:    cfg_cz_q <= cfg_data_i[ugnb_pkg::DIM_CFG_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_x_q  <= cell_x_d;
    cell_y_q  <= cell_y_d;
    cell_z_q  <= cell_z_d;
    dim_x_q   <= dim_x_d;
    dim_y_q   <= dim_y_d;
    dim_z_q   <= dim_z_d;
    cxy_q     <= cxy_d;
    id_q      <= id_d;
    rad_q     <= rad_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    dz_q      <= dz_d;
    n_q       <= n_d;
    fcnt_q    <= fcnt_d;
    slot_i_q  <= slot_i_d;
    pend_id_q <= pend_id_d;
    resp_st_q <= resp_st_d;
    if (push) begin
      out_id_q   <= push_id;
      out_fv_q   <= push_fv;
      out_st_q   <= push_st;
      out_last_q <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/ugnb_checker.sv =====
// ----------------------------------------------------------------------------
// Uniform grid binning port checker
// Checks result coding and output stall behaviour seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module ugnb_checker #(
  parameter int ID_BITS = 10
) (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [ID_BITS-1:0]               found_id_o,
  input wire logic                             found_valid_o,
  input wire logic [ugnb_pkg::STATUS_BITS-1:0] status_o,
  input wire logic                             last_o
);

  a_empty_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_valid_o) |-> (found_id_o == '0))
    else $error("Result without an id carries a non-zero id.");

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ugnb_pkg::ST_TRUNC) |-> (last_o && found_valid_o))
    else $error("Truncated status on a result that is not a final id.");

  a_drop_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ugnb_pkg::ST_OUTSIDE || status_o == ugnb_pkg::ST_FULL))
    |-> (last_o && !found_valid_o))
    else $error("Dropped add result carries an id or is not final.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
    (out_valid_o && $stable(found_id_o) && $stable(status_o) && $stable(last_o)))
    else $error("Result changed while the receiver stalled.");

endmodule

bind uniform_grid_neighbor_binning ugnb_checker #(.ID_BITS(ID_BITS)) u_ugnb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .found_id_o    (found_id_o),
  .found_valid_o (found_valid_o),
  .status_o      (status_o),
  .last_o        (last_o)
);

`default_nettype wire
